[rtl/core/qvr_pkg.sv]
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int VEC_W     = 16;                 // vector and result components
  localparam int QUAT_W    = 16;                 // Q2.14 quaternion components
  localparam int FRAC      = 28;                 // scale of the accumulator
  localparam int PROD_W    = QUAT_W + VEC_W;     // q * v
  localparam int UV_W      = PROD_W + 1;         // q x v, scale 2^14
  localparam int QUV_W     = QUAT_W + UV_W;      // q * uv, scale 2^28
  localparam int UUV_W     = QUV_W + 1;          // q x (q x v)
  localparam int ACC_W     = UUV_W + 2;          // 2*(w*uv + uuv) + v<<28 + half
  localparam int SHR_W     = ACC_W - FRAC;       // accumulator after the shift
  localparam int CFG_IDX_W = 4;
  localparam int STAGES    = 6;                  // five work stages plus output

  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_W = CFG_IDX_W'(3);

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(16384);
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) <<< (FRAC - 1);

  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

endpackage

[rtl/core/qvr_round_sat.sv]
`timescale 1ns / 1ps

module qvr_round_sat import qvr_pkg::*; (
  input  logic signed [ACC_W-1:0] acc,
  output logic signed [VEC_W-1:0] res,
  output logic                    clip
);

  logic signed [SHR_W-1:0] shr;
  logic                    ovf;

  // acc already carries the half; dropping the fraction bits is a floor
  assign shr = acc[ACC_W-1:FRAC];

  // fits in VEC_W bits only if the bits above the result sign all match it
  assign ovf = !((&shr[SHR_W-1:VEC_W-1]) || !(|shr[SHR_W-1:VEC_W-1]));

  always_comb begin
    if (ovf) begin
      res = shr[SHR_W-1] ? VEC_MIN : VEC_MAX;
    end else begin
      res = shr[VEC_W-1:0];
    end
  end

  assign clip = ovf;

endmodule

[rtl/core/quaternion_vector_rotate.sv]
`timescale 1ns / 1ps
// Rotates one vector per request by the configured quaternion.
// Each request passes every work stage and then the output register before out_valid shows its result.
// Throughput: one request per cycle while in_stall is low; out_stall backs up through per-stage
//   valid bits, so empty stages are filled while the output waits.
// Reset (synchronous, rst_n low): pipeline emptied, quaternion set to identity.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VEC_W-1:0] in_vec_x,
  input  logic signed [VEC_W-1:0] in_vec_y,
  input  logic signed [VEC_W-1:0] in_vec_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VEC_W-1:0] out_rot_x,
  output logic signed [VEC_W-1:0] out_rot_y,
  output logic signed [VEC_W-1:0] out_rot_z,
  output logic                    out_clipped,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [QUAT_W-1:0]       cfg_data
);

  // quaternion registers
  logic signed [QUAT_W-1:0] qx_r, qy_r, qz_r, qw_r;

  // stage valids: [0..4] work stages, [5] output register
  logic [STAGES-1:0] valid_r;
  logic [STAGES:0]   adv;

  // stage 1: q * v
  logic signed [PROD_W-1:0] p1_r [6];
  logic signed [VEC_W-1:0]  v1_r [3];
  // stage 2: uv = q x v
  logic signed [UV_W-1:0]   uv2_r [3];
  logic signed [VEC_W-1:0]  v2_r [3];
  // stage 3: q * uv and w * uv
  logic signed [QUV_W-1:0]  p3_r [6];
  logic signed [QUV_W-1:0]  wuv3_r [3];
  logic signed [VEC_W-1:0]  v3_r [3];
  // stage 4: uuv = q x uv
  logic signed [UUV_W-1:0]  uuv4_r [3];
  logic signed [QUV_W-1:0]  wuv4_r [3];
  logic signed [VEC_W-1:0]  v4_r [3];
  // stage 5: accumulator with the rounding half
  logic signed [ACC_W-1:0]  acc5_r [3];
  logic signed [ACC_W-1:0]  acc5_nxt [3];

  logic signed [VEC_W-1:0]  res [3];
  logic [2:0]               clip;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
      qw_r <= QUAT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUAT_X: qx_r <= cfg_data;
        CFG_QUAT_Y: qy_r <= cfg_data;
        CFG_QUAT_Z: qz_r <= cfg_data;
        CFG_QUAT_W: qw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[STAGES] = !out_stall;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) valid_r[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p1_r[0] <= PROD_W'(qy_r) * PROD_W'(in_vec_z);
      p1_r[1] <= PROD_W'(qz_r) * PROD_W'(in_vec_y);
      p1_r[2] <= PROD_W'(qz_r) * PROD_W'(in_vec_x);
      p1_r[3] <= PROD_W'(qx_r) * PROD_W'(in_vec_z);
      p1_r[4] <= PROD_W'(qx_r) * PROD_W'(in_vec_y);
      p1_r[5] <= PROD_W'(qy_r) * PROD_W'(in_vec_x);
      v1_r[0] <= in_vec_x;
      v1_r[1] <= in_vec_y;
      v1_r[2] <= in_vec_z;
    end
  end

  // ---------------- stage 2 ----------------
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        uv2_r[i] <= UV_W'(p1_r[2*i]) - UV_W'(p1_r[2*i+1]);
        v2_r[i]  <= v1_r[i];
      end
    end
  end

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      p3_r[0] <= QUV_W'(qy_r) * QUV_W'(uv2_r[2]);
      p3_r[1] <= QUV_W'(qz_r) * QUV_W'(uv2_r[1]);
      p3_r[2] <= QUV_W'(qz_r) * QUV_W'(uv2_r[0]);
      p3_r[3] <= QUV_W'(qx_r) * QUV_W'(uv2_r[2]);
      p3_r[4] <= QUV_W'(qx_r) * QUV_W'(uv2_r[1]);
      p3_r[5] <= QUV_W'(qy_r) * QUV_W'(uv2_r[0]);
      for (int i = 0; i < 3; i++) begin
        wuv3_r[i] <= QUV_W'(qw_r) * QUV_W'(uv2_r[i]);
        v3_r[i]   <= v2_r[i];
      end
    end
  end

  // ---------------- stage 4 ----------------
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        uuv4_r[i] <= UUV_W'(p3_r[2*i]) - UUV_W'(p3_r[2*i+1]);
        wuv4_r[i] <= wuv3_r[i];
        v4_r[i]   <= v3_r[i];
      end
    end
  end

  // ---------------- stage 5 ----------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc5_nxt[i] = ((ACC_W'(wuv4_r[i]) + ACC_W'(uuv4_r[i])) <<< 1)
                  + (ACC_W'(v4_r[i]) <<< FRAC) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        acc5_r[i] <= acc5_nxt[i];
      end
    end
  end

  // ---------------- round, saturate, output ----------------
  for (genvar g = 0; g < 3; g++) begin : g_fin
    qvr_round_sat u_fin (
      .acc  (acc5_r[g]),
      .res  (res[g]),
      .clip (clip[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      out_rot_x   <= res[0];
      out_rot_y   <= res[1];
      out_rot_z   <= res[2];
      out_clipped <= |clip;
    end
  end

  assign out_valid = valid_r[STAGES-1];

  // ---------------- assertions ----------------
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r))
    else $error("input stalled while a pipeline stage is empty");

  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[STAGES-2] && adv[STAGES-1]) |=> out_valid)
    else $error("result lost between last stage and output");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_rot_x == VEC_MAX || out_rot_x == VEC_MIN ||
       out_rot_y == VEC_MAX || out_rot_y == VEC_MIN ||
       out_rot_z == VEC_MAX || out_rot_z == VEC_MIN))
    else $error("clipped set with no saturated component");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0))
    else $error("pipeline not empty after reset");

endmodule
